/* src/generational_handle_allocator_assert.svh */
// assertion macros for the generational handle allocator
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/gha_pkg.sv */
// shared types, codes and defaults of the generational handle allocator
package gha_pkg;

	// defaults for the top level parameters
	localparam int unsigned POOL_SLOTS_DEF   = 256;
	localparam int unsigned VERSION_BITS_DEF = 16;

	// fixed field widths
	localparam int unsigned SLOT_IDX_W  = 8;
	localparam int unsigned VER_FIELD_W = 16;

	// width of one leaf group of the freed-slot search tree
	localparam int unsigned FREE_GROUP_BITS = 16;

	// request codes
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_CREATE = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_LIVE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	// request item
	typedef struct packed {
		logic [1:0]             req_type;
		logic [SLOT_IDX_W-1:0]  slot_index;
		logic [VER_FIELD_W-1:0] handle_version;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [SLOT_IDX_W-1:0]  result_slot;
		logic [VER_FIELD_W-1:0] result_version;
		logic [1:0]             status;
	} rsp_item_t;

	// update command for the freed map
	typedef struct packed {
		logic wr;
		logic freed;
	} free_upd_t;

endpackage

/* src/gha_stream_if.sv */
// valid/ready stream interface carrying one item per handshake
interface gha_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/gha_version_mem.sv */
// slot version memory, one write and one registered read port
module gha_version_mem #(
	parameter int unsigned DEPTH = gha_pkg::POOL_SLOTS_DEF,
	parameter int unsigned WIDTH = gha_pkg::VERSION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	import gha_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* src/gha_free_map.sv */
// freed-slot bitmap with a registered two-level lowest-set search
module gha_free_map #(
	parameter int unsigned POOL_SLOTS = gha_pkg::POOL_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(POOL_SLOTS)-1:0] rd_slot,
	output logic                          rd_freed,
	input  gha_pkg::free_upd_t            upd,
	input  logic [$clog2(POOL_SLOTS)-1:0] upd_slot,
	output logic                          found,
	output logic [$clog2(POOL_SLOTS)-1:0] lowest
);
	import gha_pkg::*;

	localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
	localparam int unsigned GRP    = FREE_GROUP_BITS;
	localparam int unsigned GW     = $clog2(GRP);
	localparam int unsigned NGRP   = (POOL_SLOTS + GRP - 1) / GRP;
	localparam int unsigned PAD_W  = NGRP * GRP;

	logic [POOL_SLOTS-1:0] freed_q;
	logic [PAD_W-1:0]      padded;
	logic [NGRP-1:0]       grp_any;
	logic [GW-1:0]         grp_idx [NGRP];
	logic [NGRP-1:0]       grp_any_q;
	logic [GW-1:0]         grp_idx_q [NGRP];
	logic [31:0]           low_full;

	// freed bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freed_q <= '0;
		end else if (upd.wr) begin
			freed_q[upd_slot] <= upd.freed;
		end
	end

	assign rd_freed = freed_q[rd_slot];

	// leaf level: lowest set bit inside each group
	assign padded = PAD_W'(freed_q);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			for (int b = GRP - 1; b >= 0; b--) begin
				if (padded[g*GRP + b]) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = GW'(b);
				end
			end
		end
	end

	// leaf results registered every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_q <= '0;
			for (int g = 0; g < NGRP; g++) begin
				grp_idx_q[g] <= '0;
			end
		end else begin
			grp_any_q <= grp_any;
			for (int g = 0; g < NGRP; g++) begin
				grp_idx_q[g] <= grp_idx[g];
			end
		end
	end

	// root level: lowest group holding a freed slot
	always_comb begin
		found    = |grp_any_q;
		low_full = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				low_full = 32'(g * GRP) + 32'(grp_idx_q[g]);
			end
		end
	end

	assign lowest = SLOT_W'(low_full);
endmodule

/* src/generational_handle_allocator.sv */
// generational handle allocator top level: sequencer, result register, state
//
//  channel  modport  payload                                        role
//  req      sink     req_type, slot_index, handle_version           requests in
//  rsp      source   result_slot, result_version, status           one result per item
//
// each item passes accept, read (freed search and version read) and
// execute (write back and load the result register)
// the read stage waits on the registered freed-search tree and the registered
// read port of the version memory; the next item is accepted after execute
// reset clears the freed map, the high-water mark and the control state at once
// a waiting result does not block acceptance; execute holds until the result
// register is free
module generational_handle_allocator #(
	parameter int unsigned POOL_SLOTS   = gha_pkg::POOL_SLOTS_DEF,
	parameter int unsigned VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	gha_stream_if.sink   req,
	gha_stream_if.source rsp
);
	import gha_pkg::*;

`include "generational_handle_allocator_assert.svh"

	localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
	localparam int unsigned HW_W   = $clog2(POOL_SLOTS + 1);
	localparam int unsigned CW     = (HW_W > SLOT_IDX_W) ? HW_W : SLOT_IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t                  state_q;
	req_item_t               req_q;
	logic [SLOT_W-1:0]       addr_q;
	logic                    reuse_q;
	logic [HW_W-1:0]         hw_q;
	rsp_item_t               rsp_q;
	logic                    rsp_valid_q;

	logic                    accept;
	logic                    exec_fire;
	logic                    in_range;
	logic                    rd_freed;
	logic                    found;
	logic [SLOT_W-1:0]       lowest;
	logic [SLOT_W-1:0]       rd_addr;
	logic [VERSION_BITS-1:0] mem_rd;
	logic                    mem_wr;
	logic [VERSION_BITS-1:0] mem_wdata;
	free_upd_t               free_upd;
	logic                    hw_inc;
	rsp_item_t               rsp_next;

	// handshake
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_READ;
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: if (exec_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
	end

	// read stage: pick the slot and read its version
	assign rd_addr = (req_q.req_type == REQ_CREATE) ? lowest : SLOT_W'(req_q.slot_index);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			reuse_q <= found;
			if (req_q.req_type == REQ_CREATE) begin
				addr_q <= found ? lowest : SLOT_W'(hw_q);
			end else begin
				addr_q <= SLOT_W'(req_q.slot_index);
			end
		end
	end

	gha_version_mem #(
		.DEPTH (POOL_SLOTS),
		.WIDTH (VERSION_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (state_q == ST_READ),
		.rd_addr (rd_addr),
		.rd_data (mem_rd),
		.wr_en   (mem_wr),
		.wr_addr (addr_q),
		.wr_data (mem_wdata)
	);

	gha_free_map #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_slot  (addr_q),
		.rd_freed (rd_freed),
		.upd      (free_upd),
		.upd_slot (addr_q),
		.found    (found),
		.lowest   (lowest)
	);

	// execute stage: decide the result and the write back
	assign in_range = CW'(req_q.slot_index) < CW'(hw_q);

	always_comb begin
		mem_wr         = 1'b0;
		mem_wdata      = '0;
		free_upd.wr    = 1'b0;
		free_upd.freed = 1'b0;
		hw_inc         = 1'b0;
		rsp_next       = '{result_slot: '0, result_version: '0, status: ST_NOT_LIVE};
		unique case (req_q.req_type)
			REQ_LOOKUP: begin
				if (in_range && !rd_freed
					&& mem_rd == VERSION_BITS'(req_q.handle_version)) begin
					rsp_next.result_slot    = req_q.slot_index;
					rsp_next.result_version = VER_FIELD_W'(mem_rd);
					rsp_next.status         = ST_OK;
				end
			end
			REQ_CREATE: begin
				if (reuse_q) begin
					mem_wr                  = 1'b1;
					mem_wdata               = mem_rd + VERSION_BITS'(1);
					free_upd.wr             = 1'b1;
					rsp_next.result_slot    = SLOT_IDX_W'(addr_q);
					rsp_next.result_version = VER_FIELD_W'(mem_wdata);
					rsp_next.status         = ST_OK;
				end else if (hw_q == HW_W'(POOL_SLOTS)) begin
					rsp_next.status = ST_FULL;
				end else begin
					mem_wr                  = 1'b1;
					mem_wdata               = VERSION_BITS'(1);
					hw_inc                  = 1'b1;
					rsp_next.result_slot    = SLOT_IDX_W'(addr_q);
					rsp_next.result_version = VER_FIELD_W'(mem_wdata);
					rsp_next.status         = ST_OK;
				end
			end
			REQ_REMOVE: begin
				rsp_next.result_slot = req_q.slot_index;
				if (in_range) begin
					free_upd.wr     = 1'b1;
					free_upd.freed  = 1'b1;
					rsp_next.status = ST_OK;
				end else begin
					rsp_next.status = ST_RANGE;
				end
			end
			default: begin
				rsp_next.status = ST_NOT_LIVE;
			end
		endcase
		if (!exec_fire) begin
			mem_wr      = 1'b0;
			free_upd.wr = 1'b0;
			hw_inc      = 1'b0;
		end
	end

	// high-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (hw_inc) begin
			hw_q <= hw_q + HW_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q <= rsp_next;
		end
	end

	// checks
	`GHA_ASSERT_IMP(a_hw_bound, 1'b1, hw_q <= HW_W'(POOL_SLOTS), "high-water mark beyond pool")
	`GHA_ASSERT_IMP(a_hw_step, hw_q != $past(hw_q),
		$past(state_q) == ST_EXEC && hw_q == $past(hw_q) + HW_W'(1),
		"high-water mark moved outside execute")
	`GHA_ASSERT_NXT(a_rsp_load, exec_fire, rsp_valid_q, "result lost after execute")
	`GHA_ASSERT_IMP(a_exec_wait, state_q == ST_EXEC && rsp_valid_q && !rsp.ready,
		!exec_fire && !mem_wr && !free_upd.wr, "write back while result register full")
endmodule
